// ----- hdl/frp_pkg.sv -----
// Package for the range / flow frame parser.
// Holds frame layout constants, register indexes and the shared stored-byte and result types.
// No dependencies.
package frp_pkg;

  localparam logic [7:0]  START_MARK       = 8'h24;
  localparam logic [15:0] RANGE_CODE_RESET = 16'h1F01;
  localparam logic [15:0] FLOW_CODE_RESET  = 16'h1F02;
  localparam logic [7:0]  POS_MAX          = 8'hFF;
  localparam int          STORE_DEPTH      = 32;

  localparam logic [7:0]  POS_TYPE_LO      = 8'd4;
  localparam logic [7:0]  POS_TYPE_HI      = 8'd5;
  localparam logic [7:0]  POS_QUALITY      = 8'd8;
  localparam logic [7:0]  POS_PAYLOAD      = 8'd9;
  localparam int          PAYLOAD_BYTES    = 8;
  localparam logic [7:0]  POS_PAYLOAD_LAST = POS_PAYLOAD + 8'(PAYLOAD_BYTES - 1);

  localparam int          CFG_INDEX_W      = 8;
  localparam int          CFG_DATA_W       = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_CODE = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FLOW_CODE  = 8'd1;

  localparam logic        KIND_RANGE       = 1'b0;
  localparam logic        KIND_FLOW        = 1'b1;

  typedef struct packed {
    logic [7:0]                    type_lo;
    logic [7:0]                    type_hi;
    logic [7:0]                    quality;
    logic [PAYLOAD_BYTES-1:0][7:0] payload;
  } frame_bytes_t;

  typedef struct packed {
    logic               frame_kind;
    logic [7:0]         quality;
    logic signed [31:0] distance;
    logic signed [31:0] flow_dx;
    logic signed [31:0] flow_dy;
  } frame_result_t;

endpackage

// ----- hdl/frp_decode.sv -----
// Frame decoder for the range / flow frame parser.
// Turns the stored frame bytes and the type codes into one result word on a start mark.
// Depends on frp_pkg.
module frp_decode import frp_pkg::*; (
  input  logic [7:0]    rx_byte,
  input  frame_bytes_t  frame,
  input  logic [15:0]   range_code,
  input  logic [15:0]   flow_code,
  output logic          hit,
  output frame_result_t result
);

  logic [15:0] frame_type;
  logic [31:0] word_a;
  logic [31:0] word_b;
  logic        is_start;
  logic        has_payload;
  logic        is_range;
  logic        is_flow;

  assign frame_type  = {frame.type_hi, frame.type_lo};
  assign word_a      = {frame.payload[3], frame.payload[2], frame.payload[1], frame.payload[0]};
  assign word_b      = {frame.payload[7], frame.payload[6], frame.payload[5], frame.payload[4]};
  assign is_start    = (rx_byte == START_MARK);
  assign has_payload = (word_a != 32'd0);
  assign is_range    = (frame_type == range_code);
  assign is_flow     = (frame_type == flow_code) && !is_range;
  assign hit         = is_start && has_payload && (is_range || is_flow);

  always_comb begin
    result.quality = frame.quality;
    if (is_range) begin
      result.frame_kind = KIND_RANGE;
      result.distance   = word_a;
      result.flow_dx    = 32'sd0;
      result.flow_dy    = 32'sd0;
    end else begin
      result.frame_kind = KIND_FLOW;
      result.distance   = 32'sd0;
      result.flow_dx    = word_a;
      result.flow_dy    = word_b;
    end
  end

endmodule

// ----- hdl/flow_range_frame_parser_core.sv -----
// Range / optical flow serial frame parser, top level.
// Byte position tracking, frame byte store, config registers and a two-deep result buffer.
// Depends on frp_pkg and frp_decode.
//
// Usage:
//   in_*  : one received byte per word (in_rx_byte), valid / stall handshake.
//   out_* : one decoded frame per word, valid / stall handshake.
//   cfg_* : register writes (index 0 range type code, index 1 flow type code);
//           cfg_ready is always high, unknown indexes are ignored.
// A byte is taken every cycle while in_stall is low. A start mark (0x24) that
// closes a frame with a known type and a nonzero first payload word yields one
// registered result, held in the output register, or in the skid entry while the
// output waits on out_stall. All other bytes yield nothing.
// The result path is an output register plus one skid entry, so a byte is
// still taken while a result waits on out_stall. in_stall rises only once
// both entries hold results, and drops the cycle after the output is taken.
// Reset (rst_n low, synchronous) clears the position counter, the frame
// bytes and the valid flags of both buffer entries, and loads the default
// type codes. No sweep is needed: bytes are accepted once reset is released.
module flow_range_frame_parser_core import frp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_rx_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_frame_kind,
  output logic [7:0]             out_quality,
  output logic signed [31:0]     out_distance,
  output logic signed [31:0]     out_flow_dx,
  output logic signed [31:0]     out_flow_dy,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [15:0]   range_code_r;
  logic [15:0]   flow_code_r;
  logic [7:0]    pos_r;
  logic [7:0]    pos_nxt;
  logic [7:0]    pos_inc;
  frame_bytes_t  frame_r;
  frame_bytes_t  frame_nxt;
  logic [2:0]    payload_idx;

  logic          in_fire;
  logic          out_fire;
  logic          dec_hit;
  frame_result_t dec_result;
  logic          res_valid;

  logic          out_valid_r;
  frame_result_t out_r;
  logic          skid_valid_r;
  frame_result_t skid_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;

  frp_decode u_decode (
    .rx_byte    (in_rx_byte),
    .frame      (frame_r),
    .range_code (range_code_r),
    .flow_code  (flow_code_r),
    .hit        (dec_hit),
    .result     (dec_result)
  );

  assign res_valid   = in_fire && dec_hit;
  assign pos_inc     = (pos_r < POS_MAX) ? pos_r + 8'd1 : pos_r;
  assign payload_idx = 3'(pos_inc - POS_PAYLOAD);

  always_comb begin
    pos_nxt   = pos_r;
    frame_nxt = frame_r;
    if (in_fire) begin
      if (in_rx_byte == START_MARK) begin
        pos_nxt = 8'd0;
      end else begin
        pos_nxt = pos_inc;
        if (pos_inc == POS_TYPE_LO) begin
          frame_nxt.type_lo = in_rx_byte;
        end else if (pos_inc == POS_TYPE_HI) begin
          frame_nxt.type_hi = in_rx_byte;
        end else if (pos_inc == POS_QUALITY) begin
          frame_nxt.quality = in_rx_byte;
        end else if (pos_inc >= POS_PAYLOAD && pos_inc <= POS_PAYLOAD_LAST) begin
          frame_nxt.payload[payload_idx] = in_rx_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_code_r <= RANGE_CODE_RESET;
      flow_code_r  <= FLOW_CODE_RESET;
      pos_r        <= 8'd0;
      frame_r      <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_RANGE_CODE: range_code_r <= cfg_data;
          CFG_FLOW_CODE:  flow_code_r  <= cfg_data;
          default: ;
        endcase
      end
      pos_r   <= pos_nxt;
      frame_r <= frame_nxt;
      if (skid_valid_r) begin
        if (out_fire) begin
          out_r        <= skid_r;
          skid_valid_r <= 1'b0;
        end
      end else if (res_valid) begin
        if (!out_valid_r || out_fire) begin
          out_r       <= dec_result;
          out_valid_r <= 1'b1;
        end else begin
          skid_r       <= dec_result;
          skid_valid_r <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_kind = out_r.frame_kind;
  assign out_quality    = out_r.quality;
  assign out_distance   = out_r.distance;
  assign out_flow_dx    = out_r.flow_dx;
  assign out_flow_dy    = out_r.flow_dy;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without an output word");

  a_start_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_rx_byte == START_MARK) |=> pos_r == 8'd0)
    else $error("start mark did not clear the byte position");

  a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_rx_byte != START_MARK) && (pos_r != POS_MAX)
    |=> pos_r == $past(pos_r) + 8'd1)
    else $error("byte position did not advance");

  a_pos_saturate: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_rx_byte != START_MARK) && (pos_r == POS_MAX) |=> pos_r == POS_MAX)
    else $error("byte position wrapped");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_stall |=> !skid_valid_r && out_valid_r)
    else $error("skid entry not moved to output");

endmodule
